// ===== design/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types, constants and the control store of the Bloom filter block.
// ----------------------------------------------------------------------------
package bfm_pkg;

  // Field and register widths.
  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = $clog2(HASH_W);
  localparam int FSIZE_W    = 11;
  localparam int HCNT_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  // Register reset values and hash seeds.
  localparam logic [FSIZE_W-1:0] FSIZE_RESET = 11'd1000;
  localparam logic [HCNT_W-1:0]  HCNT_RESET  = 2'd3;
  localparam logic [HASH_W-1:0]  SEED_A      = 32'd5381;
  localparam logic [HASH_W-1:0]  SEED_B      = 32'd0;
  localparam logic [HASH_W-1:0]  SEED_C      = 32'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 8'd1;

  // Kind codes of a key.
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Datapath action of one control word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_IDLE,
    OP_MOD_START,
    OP_MEM,
    OP_MERGE,
    OP_EMIT
  } op_t;

  // Jump condition of one control word.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CLEARING,
    COND_NO_KEY_END,
    COND_SEL_DONE,
    COND_MOD_BUSY,
    COND_OUT_BUSY
  } cond_t;

  // Control store addresses.
  typedef enum logic [3:0] {
    S_CLEAR  = 4'd0,
    S_IDLE   = 4'd1,
    S_TEST   = 4'd2,
    S_MSTART = 4'd3,
    S_MWAIT  = 4'd4,
    S_MEM    = 4'd5,
    S_MERGE  = 4'd6,
    S_EMIT   = 4'd7,
    S_DONE   = 4'd8
  } step_t;

  // One control word: action, jump condition and jump target.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } cw_t;

  // Status that the datapath returns to the sequencer.
  typedef struct packed {
    logic clear_done;
    logic key_end;
    logic sel_done;
    logic mod_busy;
    logic out_busy;
  } stat_t;

  // Control program. Each hash runs test, start, wait, access and merge.
  function automatic cw_t cw_rom(input step_t addr);
    cw_t w;
    unique case (addr)
      S_CLEAR:  w = '{op: OP_CLEAR,     cond: COND_CLEARING,   target: S_CLEAR};
      S_IDLE:   w = '{op: OP_IDLE,      cond: COND_NO_KEY_END, target: S_IDLE};
      S_TEST:   w = '{op: OP_NONE,      cond: COND_SEL_DONE,   target: S_EMIT};
      S_MSTART: w = '{op: OP_MOD_START, cond: COND_NEVER,      target: S_MSTART};
      S_MWAIT:  w = '{op: OP_NONE,      cond: COND_MOD_BUSY,   target: S_MWAIT};
      S_MEM:    w = '{op: OP_MEM,       cond: COND_NEVER,      target: S_MEM};
      S_MERGE:  w = '{op: OP_MERGE,     cond: COND_ALWAYS,     target: S_TEST};
      S_EMIT:   w = '{op: OP_EMIT,      cond: COND_OUT_BUSY,   target: S_EMIT};
      S_DONE:   w = '{op: OP_NONE,      cond: COND_ALWAYS,     target: S_IDLE};
      default:  w = '{op: OP_NONE,      cond: COND_ALWAYS,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/bfm_seq.sv =====
// ----------------------------------------------------------------------------
// bfm_seq
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module bfm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  bfm_pkg::stat_t  stat,
  output bfm_pkg::op_t    op
);

  bfm_pkg::step_t step_r;
  bfm_pkg::step_t step_nxt;
  bfm_pkg::cw_t   cw;
  logic           jump;

  // Fetch the current control word.
  assign cw = bfm_pkg::cw_rom(step_r);
  assign op = cw.op;

  // Evaluate the jump condition.
  always_comb begin
    unique case (cw.cond)
      bfm_pkg::COND_NEVER:      jump = 1'b0;
      bfm_pkg::COND_ALWAYS:     jump = 1'b1;
      bfm_pkg::COND_CLEARING:   jump = !stat.clear_done;
      bfm_pkg::COND_NO_KEY_END: jump = !stat.key_end;
      bfm_pkg::COND_SEL_DONE:   jump = stat.sel_done;
      bfm_pkg::COND_MOD_BUSY:   jump = stat.mod_busy;
      bfm_pkg::COND_OUT_BUSY:   jump = stat.out_busy;
      default:                  jump = 1'b1;
    endcase
    step_nxt = jump ? cw.target : bfm_pkg::step_t'(step_r + 1'b1);
  end

  // Step counter; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bfm_pkg::S_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/bfm_mod.sv =====
// ----------------------------------------------------------------------------
// bfm_mod
// Restoring remainder unit: a 32-bit hash modulo the filter size, one bit
// per cycle.
// ----------------------------------------------------------------------------
module bfm_mod #(
  parameter int MAX_BITS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bfm_pkg::HASH_W-1:0]   dividend,
  input  logic [$clog2(MAX_BITS+1)-1:0] divisor,
  output logic [$clog2(MAX_BITS)-1:0]  rem,
  output logic                         busy
);

  localparam int SZW  = $clog2(MAX_BITS + 1);
  localparam int IDXW = $clog2(MAX_BITS);

  logic                        busy_r;
  logic [bfm_pkg::CNT_W-1:0]   cnt_r;
  logic [bfm_pkg::HASH_W-1:0]  q_r;
  logic [SZW-1:0]              rem_r;
  logic [SZW:0]                trial;
  logic [SZW-1:0]              rem_nxt;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_r, q_r[bfm_pkg::HASH_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = SZW'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = SZW'(trial);
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= bfm_pkg::CNT_W'(bfm_pkg::HASH_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Dividend shift and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[bfm_pkg::HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  // The remainder stays below the divisor, so it fits a bit index.
  assign rem  = rem_r[IDXW-1:0];
  assign busy = busy_r;

endmodule

// ===== design/bfm_dp.sv =====
// ----------------------------------------------------------------------------
// bfm_dp
// Datapath: hash registers, configuration, filter bit memory, result
// register and status for the sequencer.
// ----------------------------------------------------------------------------
module bfm_dp #(
  parameter int MAX_BITS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfm_pkg::op_t                    op,
  output bfm_pkg::stat_t                  stat,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfm_pkg::BYTE_W-1:0]      in_tdata,
  input  logic                            in_tlast,
  input  logic [1:0]                      in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  // configuration
  input  logic                            cfg_valid,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // remainder unit
  output logic                            mod_start,
  output logic [bfm_pkg::HASH_W-1:0]      mod_dividend,
  output logic [$clog2(MAX_BITS+1)-1:0]   mod_divisor,
  input  logic [$clog2(MAX_BITS)-1:0]     mod_rem,
  input  logic                            mod_busy
);

  localparam int SZW  = $clog2(MAX_BITS + 1);
  localparam int IDXW = $clog2(MAX_BITS);
  localparam int CMPW = (SZW > bfm_pkg::FSIZE_W) ? SZW : bfm_pkg::FSIZE_W;

  logic [bfm_pkg::FSIZE_W-1:0] fsize_r;
  logic [bfm_pkg::HCNT_W-1:0]  hcnt_r;
  logic [bfm_pkg::HASH_W-1:0]  hash_a_r;
  logic [bfm_pkg::HASH_W-1:0]  hash_b_r;
  logic [bfm_pkg::HASH_W-1:0]  hash_c_r;
  logic [bfm_pkg::HASH_W-1:0]  byte_ext;
  logic                        kind_r;
  logic                        present_r;
  logic [1:0]                  sel_r;
  logic [IDXW-1:0]             clr_cnt_r;
  logic                        out_valid_r;
  logic                        out_bit_r;
  logic                        mem [MAX_BITS];
  logic                        rd_r;
  logic                        mem_we;
  logic                        mem_wd;
  logic [IDXW-1:0]             mem_wa;
  logic                        beat;
  logic                        key_end;
  logic                        out_busy;
  logic                        emit_fire;
  logic [CMPW-1:0]             fsize_ext;

  // Handshake of the input stream.
  assign in_tready = (op == bfm_pkg::OP_IDLE);
  assign beat      = in_tvalid && in_tready;
  assign key_end   = beat && in_tlast;
  assign byte_ext  = bfm_pkg::HASH_W'(in_tdata);

  // Result register is busy only for a check whose slot is still taken.
  assign out_busy  = (kind_r == bfm_pkg::KIND_CHECK) && out_valid_r && !out_tready;
  assign emit_fire = (op == bfm_pkg::OP_EMIT) && !out_busy;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r <= bfm_pkg::FSIZE_RESET;
      hcnt_r  <= bfm_pkg::HCNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bfm_pkg::CFG_FILTER_SIZE: fsize_r <= cfg_data[bfm_pkg::FSIZE_W-1:0];
        bfm_pkg::CFG_HASH_COUNT:  hcnt_r  <= cfg_data[bfm_pkg::HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter size in use: zero reads as one, large values saturate.
  always_comb begin
    fsize_ext = CMPW'(fsize_r);
    if (fsize_ext == '0) begin
      mod_divisor = SZW'(1);
    end else if (fsize_ext > CMPW'(MAX_BITS)) begin
      mod_divisor = SZW'(MAX_BITS);
    end else begin
      mod_divisor = SZW'(fsize_ext);
    end
  end

  // Hash registers: updated per key byte, restored once the key is done.
  always_ff @(posedge clk) begin
    if (!rst_n || emit_fire) begin
      hash_a_r <= bfm_pkg::SEED_A;
      hash_b_r <= bfm_pkg::SEED_B;
      hash_c_r <= bfm_pkg::SEED_C;
    end else if (beat && in_tuser[1]) begin
      hash_a_r <= (hash_a_r << 5) + hash_a_r + byte_ext;
      hash_b_r <= (hash_b_r << 5) - hash_b_r + byte_ext;
      hash_c_r <= (hash_c_r << 4) + (hash_c_r << 10) + byte_ext;
    end
  end

  // Per-key control: kind, hash select and running answer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= bfm_pkg::KIND_ADD;
      present_r <= 1'b1;
      sel_r     <= '0;
    end else if (key_end) begin
      kind_r    <= in_tuser[0];
      present_r <= 1'b1;
      sel_r     <= '0;
    end else if (op == bfm_pkg::OP_MERGE) begin
      sel_r <= sel_r + 1'b1;
      if (kind_r == bfm_pkg::KIND_CHECK) begin
        present_r <= present_r && rd_r;
      end
    end
  end

  // Clearing pass counter, one bit per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (op == bfm_pkg::OP_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Start the remainder unit on the selected hash.
  assign mod_start = (op == bfm_pkg::OP_MOD_START);
  always_comb begin
    case (sel_r)
      2'd1:    mod_dividend = hash_b_r;
      2'd2:    mod_dividend = hash_c_r;
      default: mod_dividend = hash_a_r;
    endcase
  end

  // Memory port: clearing writes zero, an add writes one.
  assign mem_we = (op == bfm_pkg::OP_CLEAR) ||
                  ((op == bfm_pkg::OP_MEM) && (kind_r == bfm_pkg::KIND_ADD));
  assign mem_wd = (op != bfm_pkg::OP_CLEAR);
  assign mem_wa = (op == bfm_pkg::OP_CLEAR) ? clr_cnt_r : mod_rem;

  // Filter bit memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mod_rem];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire && (kind_r == bfm_pkg::KIND_CHECK)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire && (kind_r == bfm_pkg::KIND_CHECK)) begin
      out_bit_r <= present_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

  // Status for the sequencer.
  assign stat.clear_done = (clr_cnt_r == IDXW'(MAX_BITS - 1));
  assign stat.key_end    = key_end;
  assign stat.sel_done   = (sel_r >= hcnt_r);
  assign stat.mod_busy   = mod_busy;
  assign stat.out_busy   = out_busy;

endmodule

// ===== design/bloom_filter_membership_top.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_membership_top
// Bloom filter with three byte-wise hashes, run by a microcoded sequencer.
//
//   Channel | Direction | Beat carries
//   --------+-----------+--------------------------------------------------
//   in_     | slave     | tdata: key_byte; tuser: kind, has_byte; tlast: last
//   out_    | master    | tdata[0]: maybe_present (check keys only)
//   cfg_    | write     | cfg_index: 0 filter_size, 1 hash_count; cfg_data
//
// Non-final beats are taken back to back. After the last beat of a key the block
// works through each selected hash in turn: the bit-serial remainder unit,
// then the memory access and sequencer steps.
// After reset the filter memory is cleared before the
// first beat is taken; configuration writes are taken at any time.
// A waiting result stalls only the end of the next check key.
// ----------------------------------------------------------------------------
module bloom_filter_membership_top #(
  parameter int MAX_BITS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] key_byte
  input  logic                            in_tlast,
  input  logic [1:0]                      in_tuser,   // [0] kind, [1] has_byte
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [0] maybe_present, rest zero
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SZW  = $clog2(MAX_BITS + 1);
  localparam int IDXW = $clog2(MAX_BITS);

  bfm_pkg::op_t               op;
  bfm_pkg::stat_t             stat;
  logic                       mod_start;
  logic [bfm_pkg::HASH_W-1:0] mod_dividend;
  logic [SZW-1:0]             mod_divisor;
  logic [IDXW-1:0]            mod_rem;
  logic                       mod_busy;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  // Sequencer over the control store.
  bfm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // Shared remainder unit.
  bfm_mod #(
    .MAX_BITS (MAX_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .rem      (mod_rem),
    .busy     (mod_busy)
  );

  // Datapath and filter memory.
  bfm_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .stat         (stat),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mod_start    (mod_start),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_rem      (mod_rem),
    .mod_busy     (mod_busy)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Bloom filter block. It runs a short table of directed beats
// and register writes and then random add and check keys of random length. It
// predicts each presence answer and compares it with the answer the block
// returns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          FILTER_BITS     = 1024;
  localparam int          RANDOM_BEATS    = 1500;
  localparam int          MAX_KEY         = 8;
  localparam int          POOL_DEPTH      = 64;
  localparam int          HOLD_CYCLES     = 600;
  localparam int          SETTLE_CYCLES   = 2 * (3 + 37 * 3);
  localparam int          CYCLE_LIMIT     = 2_000_000;
  localparam int          IDX_W           = bfm_pkg::CFG_IDX_W;
  localparam logic [31:0] DJB_SEED        = 32'd5381;
  localparam logic [10:0] FSIZE_AT_RESET  = 11'd1000;
  localparam logic [1:0]  HCOUNT_AT_RESET = 2'd3;
  localparam logic [10:0] FSIZE_TOP       = 11'h7FF;

  // Register indexes that decode to no register.
  localparam logic [bfm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
  localparam logic [bfm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_t;

  // One row of the directed plan: a register write or one input beat.
  typedef struct packed {
    row_t                           op;
    logic [bfm_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [bfm_pkg::CFG_DATA_W-1:0] reg_val;
    logic                           kind;
    logic                           has_byte;
    logic [7:0]                     key_byte;
    logic                           last;
    logic                           fixed;      // answer below is known by inspection
    logic                           fixed_val;
  } plan_row_t;

  localparam int PLAN_LEN = 33;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    // Filter is still clear after reset, so every check answers absent.
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h61, 1'b1, 1'b1, 1'b0},
    // Empty key added, then checked.
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b0, 8'hFF, 1'b1, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0},
    // Beat with neither byte nor last is dropped.
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b0, 8'h5A, 1'b0, 1'b0, 1'b0},
    // Three-byte key with a zero byte; kind only counts on the last beat.
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b1, 8'h80, 1'b1, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b1, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h80, 1'b1, 1'b0, 1'b0},
    // No hashes applied: a check always answers present.
    '{ROW_CFG, bfm_pkg::CFG_HASH_COUNT, 11'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h55, 1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b1, 8'hAA, 1'b1, 1'b0, 1'b0},
    // One hash into a one-bit filter; upper data bits must be dropped.
    '{ROW_CFG, bfm_pkg::CFG_HASH_COUNT, 11'h7FD, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, bfm_pkg::CFG_FILTER_SIZE, 11'd1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h01, 1'b1, 1'b0, 1'b0},
    // Size zero behaves as size one.
    '{ROW_CFG, bfm_pkg::CFG_FILTER_SIZE, 11'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h7F, 1'b1, 1'b0, 1'b0},
    // Oversized filter saturates at the memory size.
    '{ROW_CFG, bfm_pkg::CFG_FILTER_SIZE, 11'h7FF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, bfm_pkg::CFG_HASH_COUNT, 11'd2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b1, 8'h12, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_ADD,   1'b1, 8'h34, 1'b1, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h12, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h34, 1'b1, 1'b0, 1'b0},
    // Writes to unmapped indexes change nothing.
    '{ROW_CFG, CFG_UNMAPPED_LO, 11'h7FF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, CFG_UNMAPPED_HI, 11'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h99, 1'b1, 1'b0, 1'b0},
    // Full size with all three hashes.
    '{ROW_CFG, bfm_pkg::CFG_FILTER_SIZE, 11'd1024, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, bfm_pkg::CFG_HASH_COUNT, 11'd3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h12, 1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b1, 8'h34, 1'b1, 1'b0, 1'b0},
    '{ROW_BEAT, '0, '0, bfm_pkg::KIND_CHECK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // [7:0] key_byte
  logic                           in_tlast;
  logic [1:0]                     in_tuser;   // [0] kind, [1] has_byte
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;  // [0] maybe_present, [7:1] zero
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bfm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfm_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predicted filter state and register copies.
  logic [31:0]            acc_djb;
  logic [31:0]            acc_x31;
  logic [31:0]            acc_shift;
  logic [FILTER_BITS-1:0] filter_mem;
  logic [10:0]            size_reg;
  logic [1:0]             count_reg;

  logic presence_q [$];
  int   mismatches;
  int   beats_sent;
  int   in_run;
  bit   hold_req;

  // Keys already added, replayed by later checks so that hits occur.
  logic [7:0] pool_key [0:POOL_DEPTH-1][0:MAX_KEY-1];
  int         pool_len [0:POOL_DEPTH-1];
  int         pool_n;
  int         pool_wr;
  logic [7:0] key_buf [0:MAX_KEY-1];
  int         key_len;

  bloom_filter_membership_top #(.MAX_BITS(FILTER_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait length before a beat: mostly none or short, now and then long, with
  // occasional runs of back-to-back beats.
  function automatic int pick_wait(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      run_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Advances the hashes by one beat; on the last beat applies the key to the
  // filter and reports whether a presence answer follows.
  function automatic void filter_step(input logic kind, input logic has_byte,
                                      input logic [7:0] key_byte, input logic last,
                                      output bit answers, output logic present);
    logic [31:0] hashes [0:2];
    logic [31:0] modulus;
    logic [31:0] slot;
    answers = 1'b0;
    present = 1'b1;
    if (has_byte) begin
      acc_djb   = (acc_djb << 5) + acc_djb + key_byte;
      acc_x31   = acc_x31 * 31 + key_byte;
      acc_shift = (acc_shift << 4) + (acc_shift << 10) + key_byte;
    end
    if (!last) return;
    hashes[0] = acc_djb;
    hashes[1] = acc_x31;
    hashes[2] = acc_shift;
    modulus = (size_reg == 0) ? 1 : (size_reg > FILTER_BITS ? FILTER_BITS : size_reg);
    for (int i = 0; i < count_reg; i++) begin
      slot = hashes[i] % modulus;
      if (kind == bfm_pkg::KIND_ADD) filter_mem[slot] = 1'b1;
      else if (!filter_mem[slot]) present = 1'b0;
    end
    acc_djb   = DJB_SEED;
    acc_x31   = '0;
    acc_shift = '0;
    answers = (kind == bfm_pkg::KIND_CHECK);
  endfunction

  // Offers one input beat and records its predicted answer once accepted.
  task automatic send_item(input logic kind, input logic has_byte, input logic [7:0] key_byte,
                           input logic last, input logic fixed, input logic fixed_val);
    int   gap;
    bit   answers;
    logic present;
    gap = pick_wait(in_run);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key_byte;
    in_tuser  <= {has_byte, kind};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    filter_step(kind, has_byte, key_byte, last, answers, present);
    if (answers) presence_q.push_back(fixed ? fixed_val : present);
    if (has_byte || last) beats_sent++;
  endtask

  // Stops the input, waits for every answer, then lets a trailing add finish.
  task automatic wait_filter_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (presence_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bfm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bfm_pkg::CFG_FILTER_SIZE) size_reg = val;
    else if (idx == bfm_pkg::CFG_HASH_COUNT) count_reg = val[1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random key: mostly well-formed adds and checks, some raw beat noise.
  task automatic send_random_key();
    int   r;
    int   pick;
    bit   term;
    logic kind;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      key_len = $urandom_range(1, 6);
      for (int i = 0; i < key_len; i++)
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), i == key_len - 1, 1'b0, 1'b0);
      return;
    end
    kind = (r < 50) ? bfm_pkg::KIND_ADD : bfm_pkg::KIND_CHECK;
    if (kind == bfm_pkg::KIND_CHECK && pool_n > 0 && $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, pool_n - 1);
      key_len = pool_len[pick];
      for (int i = 0; i < key_len; i++) key_buf[i] = pool_key[pick][i];
    end else begin
      key_len = ($urandom_range(0, 19) == 0) ? MAX_KEY : $urandom_range(0, 5);
      for (int i = 0; i < key_len; i++) key_buf[i] = 8'($urandom_range(0, 255));
    end
    term = (key_len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < key_len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(1'($urandom_range(0, 1)), 1'b0, 8'($urandom_range(0, 255)),
                  1'b0, 1'b0, 1'b0);
      if (i == key_len - 1 && !term)
        send_item(kind, 1'b1, key_buf[i], 1'b1, 1'b0, 1'b0);
      else
        send_item(1'($urandom_range(0, 1)), 1'b1, key_buf[i], 1'b0, 1'b0, 1'b0);
    end
    if (term) send_item(kind, 1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
    if (kind == bfm_pkg::KIND_ADD) begin
      for (int i = 0; i < key_len; i++) pool_key[pool_wr][i] = key_buf[i];
      pool_len[pool_wr] = key_len;
      pool_wr = (pool_wr + 1) % POOL_DEPTH;
      if (pool_n < POOL_DEPTH) pool_n++;
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int run_left;
    int stall_left;
    int hold_left;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_wait(run_left);
      end
    end
  end

  // Compare each accepted answer beat with the oldest prediction.
  initial begin
    logic want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (presence_q.size() == 0) begin
          $error("unexpected answer beat: maybe_present actual %0b", out_tdata[0]);
          mismatches++;
        end else begin
          want = presence_q.pop_front();
          if (out_tdata[0] !== want) begin
            $error("maybe_present: expected %0b, actual %0b", want, out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[7:1] !== 7'd0) begin
            $error("tdata padding: expected 0x00, actual 0x%02h", out_tdata[7:1]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence: reset, directed plan, random phases, drain.
  initial begin
    int          phase;
    int          phase_end;
    int          r;
    logic [10:0] fsize;
    mismatches = 0;
    beats_sent = 0;
    in_run     = 0;
    hold_req   = 1'b0;
    pool_n     = 0;
    pool_wr    = 0;
    key_len    = 0;
    acc_djb    = DJB_SEED;
    acc_x31    = '0;
    acc_shift  = '0;
    filter_mem = '0;
    size_reg   = FSIZE_AT_RESET;
    count_reg  = HCOUNT_AT_RESET;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].op == ROW_CFG) begin
        wait_filter_idle();
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        send_item(PLAN[i].kind, PLAN[i].has_byte, PLAN[i].key_byte, PLAN[i].last,
                  PLAN[i].fixed, PLAN[i].fixed_val);
      end
    end

    // Random phases, each under its own register setting.
    phase = 0;
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      wait_filter_idle();
      r = $urandom_range(0, 9);
      case (r)
        0:       fsize = 11'd0;
        1:       fsize = 11'd1;
        2:       fsize = 11'(FILTER_BITS);
        3:       fsize = FSIZE_TOP;
        4, 5:    fsize = 11'($urandom_range(2, 64));
        default: fsize = 11'($urandom_range(65, FSIZE_TOP));
      endcase
      write_reg(bfm_pkg::CFG_FILTER_SIZE, fsize);
      write_reg(bfm_pkg::CFG_HASH_COUNT,
                {9'($urandom_range(0, 511)),
                 ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3))});
      if ($urandom_range(0, 4) == 0)
        write_reg(IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                  11'($urandom_range(0, FSIZE_TOP)));
      // One phase starves the result side so the block backs up its input.
      if (phase == 2) hold_req = 1'b1;
      phase_end = beats_sent + $urandom_range(60, 200);
      while (beats_sent < phase_end) send_random_key();
      phase++;
    end
    wait_filter_idle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bfm_pkg.sv
design/bfm_seq.sv
design/bfm_mod.sv
design/bfm_dp.sv
design/bloom_filter_membership_top.sv
dv/tb_top.sv
